/* rtl/core/i2cmwp_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmwp_pkg
// shared types and constants of the i2c master write phaser
// ----------------------------------------------------------------------------
package i2cmwp_pkg;

  // command opcodes
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_SEND_BYTE = 3'd2;
  localparam logic [2:0] OP_ACK_BEGIN = 3'd3;
  localparam logic [2:0] OP_ACK_SAMPLE = 3'd4;

  // phase status codes
  localparam logic [1:0] STATUS_PLAIN   = 2'd0;
  localparam logic [1:0] STATUS_ACK_RX  = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
  localparam logic [1:0] STATUS_WAITING = 2'd3;

  // hold times in microseconds
  localparam logic [2:0] HOLD_NONE  = 3'd0;
  localparam logic [2:0] HOLD_ACK   = 3'd1;
  localparam logic [2:0] HOLD_BIT   = 3'd2;
  localparam logic [2:0] HOLD_SETUP = 3'd5;
  localparam logic [2:0] HOLD_LONG  = 3'd6;

  localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

  // send byte: one scl low phase then three phases per bit
  localparam int unsigned PHASE_W        = 5;
  localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE = 5'd24;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef enum logic [2:0] {
    JOB_START,
    JOB_STOP,
    JOB_STOP_TIMEOUT,
    JOB_BYTE,
    JOB_ACK_BEGIN,
    JOB_ACK_RX,
    JOB_WAIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* rtl/core/i2cmwp_front.sv */
// ----------------------------------------------------------------------------
// i2cmwp_front
// decodes commands into phase jobs and tracks the acknowledge wait
// ----------------------------------------------------------------------------
module i2cmwp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              accept,
  input  logic [2:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic              sda_sample,
  output logic              push,
  output i2cmwp_pkg::job_t  job
);

  logic       ack_waiting;
  logic       ack_waiting_next;
  logic [7:0] poll_count;
  logic [7:0] poll_count_next;
  logic [7:0] ack_poll_limit;
  logic [8:0] poll_inc;

  assign poll_inc = {1'b0, poll_count} + 9'd1;

  always_comb begin
    push             = 1'b0;
    job.kind         = i2cmwp_pkg::JOB_WAIT;
    job.data         = data_byte;
    ack_waiting_next = 1'b0;
    poll_count_next  = 8'd0;
    case (opcode)
      i2cmwp_pkg::OP_START: begin
        push     = 1'b1;
        job.kind = i2cmwp_pkg::JOB_START;
      end
      i2cmwp_pkg::OP_STOP: begin
        push     = 1'b1;
        job.kind = i2cmwp_pkg::JOB_STOP;
      end
      i2cmwp_pkg::OP_SEND_BYTE: begin
        push     = 1'b1;
        job.kind = i2cmwp_pkg::JOB_BYTE;
      end
      i2cmwp_pkg::OP_ACK_BEGIN: begin
        push             = 1'b1;
        job.kind         = i2cmwp_pkg::JOB_ACK_BEGIN;
        ack_waiting_next = 1'b1;
      end
      i2cmwp_pkg::OP_ACK_SAMPLE: begin
        push = 1'b1;
        if (!ack_waiting) begin
          job.kind = i2cmwp_pkg::JOB_WAIT;
        end else if (!sda_sample) begin
          job.kind = i2cmwp_pkg::JOB_ACK_RX;
        end else if (poll_inc > {1'b0, ack_poll_limit}) begin
          job.kind = i2cmwp_pkg::JOB_STOP_TIMEOUT;
        end else begin
          job.kind         = i2cmwp_pkg::JOB_WAIT;
          ack_waiting_next = 1'b1;
          poll_count_next  = poll_inc[7:0];
        end
      end
      default: begin
        // unused opcodes leave state alone
        ack_waiting_next = ack_waiting;
        poll_count_next  = poll_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_waiting    <= 1'b0;
      poll_count     <= 8'd0;
      ack_poll_limit <= i2cmwp_pkg::ACK_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        ack_poll_limit <= cfg_wdata;
      end
      if (accept) begin
        ack_waiting <= ack_waiting_next;
        poll_count  <= poll_count_next;
      end
    end
  end

endmodule

/* rtl/core/i2cmwp_queue.sv */
// ----------------------------------------------------------------------------
// i2cmwp_queue
// short job queue between decode and phase sequencer
// ----------------------------------------------------------------------------
module i2cmwp_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  i2cmwp_pkg::job_t          job_in,
  input  logic                      pop,
  output i2cmwp_pkg::job_t          job_out,
  output i2cmwp_pkg::queue_stat_t   stat
);

  i2cmwp_pkg::job_t                        entries [i2cmwp_pkg::QUEUE_DEPTH];
  logic [i2cmwp_pkg::QUEUE_AW-1:0]         wr_ptr;
  logic [i2cmwp_pkg::QUEUE_AW-1:0]         rd_ptr;
  logic [i2cmwp_pkg::QUEUE_CW-1:0]         count;

  assign stat.full  = (count == i2cmwp_pkg::QUEUE_CW'(i2cmwp_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign job_out    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/i2cmwp_back.sv */
// ----------------------------------------------------------------------------
// i2cmwp_back
// phase sequencer: unless the output stalls, plays each job out as pin phases, one per cycle
// ----------------------------------------------------------------------------
module i2cmwp_back (
  input  logic                     clk,
  input  logic                     rst,
  input  i2cmwp_pkg::job_t         head,
  input  i2cmwp_pkg::queue_stat_t  q_stat,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     scl_out,
  output logic                     sda_out,
  output logic                     sda_drive,
  output logic [2:0]               hold_us,
  output logic [1:0]               status,
  output logic                     last
);

  logic                                busy;
  i2cmwp_pkg::job_kind_t               kind;
  logic [7:0]                          shreg;
  logic [i2cmwp_pkg::PHASE_W-1:0]      phase;
  logic [1:0]                          sub;
  logic                                scl_level;
  logic                                sda_level;
  logic                                sda_driven;

  logic                                adv;
  logic                                active;
  i2cmwp_pkg::job_kind_t               cur_kind;
  logic [7:0]                          cur_data;
  logic [i2cmwp_pkg::PHASE_W-1:0]      cur_phase;
  logic [1:0]                          cur_sub;

  logic                                scl_next;
  logic                                sda_next;
  logic                                drive_next;
  logic [2:0]                          hold_next;
  logic [1:0]                          status_next;
  logic                                last_next;
  logic [7:0]                          shreg_next;
  logic [1:0]                          sub_next;

  assign adv       = !out_valid || out_ready;
  assign active    = busy || !q_stat.empty;
  assign pop       = adv && !busy && !q_stat.empty;
  assign cur_kind  = busy ? kind  : head.kind;
  assign cur_data  = busy ? shreg : head.data;
  assign cur_phase = busy ? phase : '0;
  assign cur_sub   = busy ? sub   : 2'd0;

  always_comb begin
    scl_next    = scl_level;
    sda_next    = sda_level;
    drive_next  = sda_driven;
    hold_next   = i2cmwp_pkg::HOLD_NONE;
    status_next = i2cmwp_pkg::STATUS_PLAIN;
    last_next   = 1'b0;
    shreg_next  = cur_data;
    sub_next    = 2'd0;
    case (cur_kind)
      i2cmwp_pkg::JOB_START: begin
        case (cur_phase[1:0])
          2'd0: begin
            drive_next = 1'b1;
            sda_next   = 1'b1;
          end
          2'd1: begin
            scl_next  = 1'b1;
            hold_next = i2cmwp_pkg::HOLD_SETUP;
          end
          2'd2: begin
            drive_next = 1'b1;
            sda_next   = 1'b0;
            hold_next  = i2cmwp_pkg::HOLD_LONG;
          end
          default: begin
            scl_next  = 1'b0;
            last_next = 1'b1;
          end
        endcase
      end
      i2cmwp_pkg::JOB_STOP, i2cmwp_pkg::JOB_STOP_TIMEOUT: begin
        status_next = (cur_kind == i2cmwp_pkg::JOB_STOP_TIMEOUT) ?
                      i2cmwp_pkg::STATUS_TIMEOUT : i2cmwp_pkg::STATUS_PLAIN;
        case (cur_phase[1:0])
          2'd0: begin
            scl_next = 1'b0;
          end
          2'd1: begin
            drive_next = 1'b1;
            sda_next   = 1'b0;
          end
          2'd2: begin
            scl_next  = 1'b1;
            hold_next = i2cmwp_pkg::HOLD_LONG;
          end
          default: begin
            drive_next = 1'b1;
            sda_next   = 1'b1;
            hold_next  = i2cmwp_pkg::HOLD_LONG;
            last_next  = 1'b1;
          end
        endcase
      end
      i2cmwp_pkg::JOB_BYTE: begin
        if (cur_phase == '0) begin
          scl_next = 1'b0;
        end else begin
          hold_next = i2cmwp_pkg::HOLD_BIT;
          last_next = (cur_phase == i2cmwp_pkg::BYTE_LAST_PHASE);
          case (cur_sub)
            2'd0: begin
              drive_next = 1'b1;
              sda_next   = cur_data[7];
              sub_next   = 2'd1;
            end
            2'd1: begin
              scl_next = 1'b1;
              sub_next = 2'd2;
            end
            default: begin
              // bit done, move the next one to the top
              scl_next   = 1'b0;
              shreg_next = {cur_data[6:0], 1'b0};
              sub_next   = 2'd0;
            end
          endcase
        end
      end
      i2cmwp_pkg::JOB_ACK_BEGIN: begin
        hold_next = i2cmwp_pkg::HOLD_ACK;
        case (cur_phase[1:0])
          2'd0: begin
            drive_next = 1'b1;
            sda_next   = 1'b1;
          end
          2'd1: begin
            scl_next = 1'b1;
          end
          default: begin
            drive_next = 1'b0;
            sda_next   = 1'b1;
            last_next  = 1'b1;
          end
        endcase
      end
      i2cmwp_pkg::JOB_ACK_RX: begin
        scl_next    = 1'b0;
        status_next = i2cmwp_pkg::STATUS_ACK_RX;
        last_next   = 1'b1;
      end
      default: begin
        status_next = i2cmwp_pkg::STATUS_WAITING;
        last_next   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      sda_driven <= 1'b0;
    end else if (adv) begin
      out_valid <= active;
      if (active) begin
        busy       <= !last_next;
        scl_level  <= scl_next;
        sda_level  <= sda_next;
        sda_driven <= drive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && active) begin
      kind      <= cur_kind;
      shreg     <= shreg_next;
      phase     <= cur_phase + 1'b1;
      sub       <= sub_next;
      scl_out   <= scl_next;
      sda_out   <= sda_next;
      sda_drive <= drive_next;
      hold_us   <= hold_next;
      status    <= status_next;
      last      <= last_next;
    end
  end

endmodule

/* rtl/core/i2c_master_write_phaser.sv */
// ----------------------------------------------------------------------------
// i2c_master_write_phaser
// i2c master transmitter turning commands into a run of timed pin phases
// ----------------------------------------------------------------------------
//
// channel   dir  width  contents
// s_axis    in   16     command: opcode, data_byte, sda_sample
// m_axis    out  8+1    phase: scl, sda, drive, hold_us, status; tlast = last
// cfg       in   8      ack_poll_limit, written when cfg_we is high
//
// one phase beat leaves per cycle while m_tready is high; a send byte command
// gives 25 phase beats, start and stop 4, ack begin 3, an ack sample 1 (4 on
// timeout); the phase sequencer sets these counts, jobs follow with no gap
// commands enter one per cycle while the 4-entry job queue has room
// rst is synchronous: bus idle high, sda released, no wait, limit 250
// a stalled output beat holds the sequencer; decode keeps filling the queue
//
module i2c_master_write_phaser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // ack_poll_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [2:0] opcode, [10:3] data_byte,
                                     // [11] sda_sample, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // [0] scl_out, [1] sda_out, [2] sda_drive,
                                     // [5:3] hold_us, [7:6] status
  output logic        m_tlast        // last phase of the command
);

  logic                     accept;
  logic                     push;
  logic                     pop;
  i2cmwp_pkg::job_t         job_in;
  i2cmwp_pkg::job_t         job_head;
  i2cmwp_pkg::queue_stat_t  q_stat;

  logic                     scl_out;
  logic                     sda_out;
  logic                     sda_drive;
  logic [2:0]               hold_us;
  logic [1:0]               status;

  // the front only waits for queue space, never for the sequencer
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // decode and acknowledge bookkeeping
  i2cmwp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .opcode     (s_tdata[2:0]),
    .data_byte  (s_tdata[10:3]),
    .sda_sample (s_tdata[11]),
    .push       (push),
    .job        (job_in)
  );

  // jobs waiting for the sequencer; unused opcodes never get in
  i2cmwp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept && push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_head),
    .stat    (q_stat)
  );

  // phase sequencer with the output register
  i2cmwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (job_head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .sda_drive (sda_drive),
    .hold_us   (hold_us),
    .status    (status),
    .last      (m_tlast)
  );

  assign m_tdata = {status, hold_us, sda_drive, sda_out, scl_out};

`ifndef NO_ASSERTIONS
  // timeout beats only come from the stop sequence
  a_timeout_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == i2cmwp_pkg::STATUS_TIMEOUT) |->
      (hold_us == i2cmwp_pkg::HOLD_NONE || hold_us == i2cmwp_pkg::HOLD_LONG))
    else $error("timeout beat with a hold outside the stop sequence");

  // an acknowledge completes in a single scl-low beat
  a_ack_rx : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == i2cmwp_pkg::STATUS_ACK_RX) |-> (!scl_out && m_tlast))
    else $error("ack received beat is not a lone scl low phase");

  // reset empties the output and frees the queue
  a_reset : assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("output or queue not cleared by reset");
`endif

endmodule

/* bench/i2c_master_write_phaser_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_phaser_check
// watches the command and phase streams, works out the pin phases each
// command should give and compares every phase beat against them
// ----------------------------------------------------------------------------
module i2c_master_write_phaser_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  output int          mismatches,
  output int          phases_due
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic [2:0] hold;
    logic [1:0] status;
    logic       last;
  } pin_phase_t;

  pin_phase_t pin_phases_due[$];

  // own copy of the bus and acknowledge state
  logic [7:0] poll_limit;
  logic       scl_lvl;
  logic       sda_lvl;
  logic       sda_drv;
  logic       in_ack_wait;
  logic [7:0] high_polls;

  initial mismatches = 0;

  task automatic add_phase(input logic [2:0] hold, input logic [1:0] status,
                           input logic last);
    pin_phase_t p;
    p.scl    = scl_lvl;
    p.sda    = sda_lvl;
    p.drive  = sda_drv;
    p.hold   = hold;
    p.status = status;
    p.last   = last;
    pin_phases_due.push_back(p);
  endtask

  task automatic drive_sda_to(input logic level);
    sda_drv = 1'b1;
    sda_lvl = level;
  endtask

  task automatic add_stop(input logic [1:0] status);
    scl_lvl = 1'b0;
    add_phase(i2cmwp_pkg::HOLD_NONE, status, 1'b0);
    drive_sda_to(1'b0);
    add_phase(i2cmwp_pkg::HOLD_NONE, status, 1'b0);
    scl_lvl = 1'b1;
    add_phase(i2cmwp_pkg::HOLD_LONG, status, 1'b0);
    drive_sda_to(1'b1);
    add_phase(i2cmwp_pkg::HOLD_LONG, status, 1'b1);
  endtask

  task automatic predict_phases(input logic [2:0] op, input logic [7:0] data,
                                input logic sda_bit);
    // unused opcodes leave everything alone
    if (op > i2cmwp_pkg::OP_ACK_SAMPLE) return;
    // any other command abandons a pending acknowledge wait
    if (op != i2cmwp_pkg::OP_ACK_SAMPLE) begin
      in_ack_wait = 1'b0;
      high_polls  = 8'd0;
    end
    case (op)
      i2cmwp_pkg::OP_START: begin
        drive_sda_to(1'b1);
        add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        scl_lvl = 1'b1;
        add_phase(i2cmwp_pkg::HOLD_SETUP, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        drive_sda_to(1'b0);
        add_phase(i2cmwp_pkg::HOLD_LONG, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        scl_lvl = 1'b0;
        add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_PLAIN, 1'b1);
      end
      i2cmwp_pkg::OP_STOP: add_stop(i2cmwp_pkg::STATUS_PLAIN);
      i2cmwp_pkg::OP_SEND_BYTE: begin
        scl_lvl = 1'b0;
        add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        for (int i = 7; i >= 0; i--) begin
          drive_sda_to(data[i]);
          add_phase(i2cmwp_pkg::HOLD_BIT, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
          scl_lvl = 1'b1;
          add_phase(i2cmwp_pkg::HOLD_BIT, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
          scl_lvl = 1'b0;
          add_phase(i2cmwp_pkg::HOLD_BIT, i2cmwp_pkg::STATUS_PLAIN, i == 0);
        end
      end
      i2cmwp_pkg::OP_ACK_BEGIN: begin
        drive_sda_to(1'b1);
        add_phase(i2cmwp_pkg::HOLD_ACK, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        scl_lvl = 1'b1;
        add_phase(i2cmwp_pkg::HOLD_ACK, i2cmwp_pkg::STATUS_PLAIN, 1'b0);
        sda_drv = 1'b0;
        sda_lvl = 1'b1;
        add_phase(i2cmwp_pkg::HOLD_ACK, i2cmwp_pkg::STATUS_PLAIN, 1'b1);
        in_ack_wait = 1'b1;
        high_polls  = 8'd0;
      end
      default: begin
        if (!in_ack_wait) begin
          add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_WAITING, 1'b1);
        end else if (!sda_bit) begin
          scl_lvl = 1'b0;
          add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_ACK_RX, 1'b1);
          in_ack_wait = 1'b0;
          high_polls  = 8'd0;
        end else if (high_polls >= poll_limit) begin
          // this sample takes the count past the limit
          in_ack_wait = 1'b0;
          high_polls  = 8'd0;
          add_stop(i2cmwp_pkg::STATUS_TIMEOUT);
        end else begin
          high_polls = high_polls + 8'd1;
          add_phase(i2cmwp_pkg::HOLD_NONE, i2cmwp_pkg::STATUS_WAITING, 1'b1);
        end
      end
    endcase
  endtask

  task automatic flag_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: phase %s mismatch, expected %0d, got %0d", $time, name, want_v,
               got_v);
      mismatches++;
    end
  endtask

  task automatic check_phase();
    pin_phase_t want;
    if (pin_phases_due.size() == 0) begin
      $display("%0t: phase beat with none expected, expected nothing, got %h last %b",
               $time, m_tdata, m_tlast);
      mismatches++;
    end else begin
      want = pin_phases_due.pop_front();
      flag_field("scl", int'(want.scl), int'(m_tdata[0]));
      flag_field("sda", int'(want.sda), int'(m_tdata[1]));
      flag_field("drive", int'(want.drive), int'(m_tdata[2]));
      flag_field("hold_us", int'(want.hold), int'(m_tdata[5:3]));
      flag_field("status", int'(want.status), int'(m_tdata[7:6]));
      flag_field("last", int'(want.last), int'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      poll_limit  = i2cmwp_pkg::ACK_LIMIT_RESET;
      scl_lvl     = 1'b1;
      sda_lvl     = 1'b1;
      sda_drv     = 1'b0;
      in_ack_wait = 1'b0;
      high_polls  = 8'd0;
      pin_phases_due.delete();
    end else begin
      if (s_tvalid && s_tready) predict_phases(s_tdata[2:0], s_tdata[10:3], s_tdata[11]);
      if (m_tvalid && m_tready) check_phase();
      if (cfg_we) poll_limit = cfg_wdata;
    end
    phases_due <= pin_phases_due.size();
  end

endmodule

/* bench/i2c_master_write_phaser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_phaser_test
// drives i2c commands and limit settings into the phaser and gives the
// verdict; a checker beside the block predicts and compares every phase
// ----------------------------------------------------------------------------
module i2c_master_write_phaser_test;

  // sender stops idling for this span of counted commands
  localparam int CALM_FIRST = 150;
  localparam int CALM_LAST  = 260;
  // receiver stops stalling for this span of its own cycles
  localparam int RX_CALM_FIRST = 3000;
  localparam int RX_CALM_LAST  = 6000;
  // long receiver hold-off so the job queue fills and s_tready drops
  localparam int RX_HOLD_CYCLES = 300;
  // quiet cycles after the last phase before anything else happens
  localparam int SETTLE_CYCLES = 40;
  // generous bound, several times the slowest correct run
  localparam int TIMEOUT_NS = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int mismatches;
  int phases_due;
  int commands_sent;  // ignored opcodes are not counted
  int limit_now;
  int hold_req;
  int hold_done;

  i2c_master_write_phaser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  i2c_master_write_phaser_check phase_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .phases_due (phases_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // phase receiver: random stalls, a calm window, and hold-offs on request
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (hold_req != hold_done) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_cycles += RX_HOLD_CYCLES;
        hold_done++;
      end
      if (rx_cycles >= RX_CALM_FIRST && rx_cycles < RX_CALM_LAST)
        m_tready <= 1'b1;
      else
        m_tready <= ($urandom_range(99) >= 6);
    end
  end

  // one command beat; may idle first, then waits for the handshake
  task automatic send_command(input logic [2:0] op, input logic [7:0] data,
                              input logic sda_bit);
    if (!(commands_sent >= CALM_FIRST && commands_sent < CALM_LAST) &&
        $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, sda_bit, data, op};
    do @(posedge clk); while (!s_tready);
    if (op <= i2cmwp_pkg::OP_ACK_SAMPLE) commands_sent++;
  endtask

  // hold the sender until every phase has come out and the block is quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (phases_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[7:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
  endtask

  // ack wait with a run of high samples; a low one ends it unless it timed out
  task automatic ack_cycle(input int highs, output logic timed_out);
    send_command(i2cmwp_pkg::OP_ACK_BEGIN, 8'($urandom), 1'($urandom));
    repeat (highs) send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'($urandom), 1'b1);
    timed_out = (highs > limit_now);
    if (!timed_out) send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'($urandom), 1'b0);
  endtask

  // write frame: start, address and data bytes each acked, a stop on most frames
  task automatic write_frame(input int max_polls);
    int   n_bytes;
    int   highs;
    logic timed_out;
    n_bytes   = $urandom_range(1, 3);
    timed_out = 1'b0;
    send_command(i2cmwp_pkg::OP_START, 8'($urandom), 1'($urandom));
    for (int b = 0; b < n_bytes && !timed_out; b++) begin
      send_command(i2cmwp_pkg::OP_SEND_BYTE, 8'($urandom), 1'($urandom));
      if ($urandom_range(3) == 0) highs = limit_now + 1;
      else highs = $urandom_range(0, 3);
      if (highs > max_polls) highs = $urandom_range(0, max_polls);
      ack_cycle(highs, timed_out);
    end
    // after a timeout the block has already sent its own stop
    if (!timed_out || $urandom_range(1) == 0) begin
      if ($urandom_range(9) != 0)
        send_command(i2cmwp_pkg::OP_STOP, 8'($urandom), 1'($urandom));
    end
  endtask

  // mostly frames with random content, the rest loose commands of any opcode
  task automatic run_setting(input int limit, input int n_items, input int max_polls);
    int first;
    write_limit(limit);
    first = commands_sent;
    while (commands_sent - first < n_items) begin
      if ($urandom_range(9) == 0)
        send_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      else
        write_frame(max_polls);
    end
  endtask

  initial begin
    logic timed_out;
    commands_sent = 0;
    hold_req      = 0;
    hold_done     = 0;
    limit_now     = int'(i2cmwp_pkg::ACK_LIMIT_RESET);
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 8'd0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 16'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset limit
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b1);  // sample with no wait
    send_command(i2cmwp_pkg::OP_START, 8'hFF, 1'b0);
    send_command(i2cmwp_pkg::OP_SEND_BYTE, 8'h00, 1'b1);
    send_command(i2cmwp_pkg::OP_ACK_BEGIN, 8'h00, 1'b0);
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b0);  // acknowledge received
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'hFF, 1'b0);  // low sample after the wait
    send_command(i2cmwp_pkg::OP_SEND_BYTE, 8'hFF, 1'b0);
    send_command(i2cmwp_pkg::OP_ACK_BEGIN, 8'h00, 1'b1);
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b1);  // still waiting
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b1);
    send_command(i2cmwp_pkg::OP_SEND_BYTE, 8'hA5, 1'b0);   // byte abandons the wait
    send_command(i2cmwp_pkg::OP_ACK_BEGIN, 8'h00, 1'b0);
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b1);
    send_command(i2cmwp_pkg::OP_ACK_SAMPLE, 8'h00, 1'b0);
    send_command(3'd5, 8'h5A, 1'b1);           // unused opcodes, nothing comes out
    send_command(3'd6, 8'hFF, 1'b0);
    send_command(3'd7, 8'hC3, 1'b1);
    send_command(i2cmwp_pkg::OP_STOP, 8'h00, 1'b0);
    send_command(i2cmwp_pkg::OP_STOP, 8'hFF, 1'b1);
    send_command(i2cmwp_pkg::OP_START, 8'h00, 1'b0);
    send_command(i2cmwp_pkg::OP_START, 8'h00, 1'b0);       // repeated start
    send_command(i2cmwp_pkg::OP_ACK_BEGIN, 8'h00, 1'b1);
    send_command(i2cmwp_pkg::OP_STOP, 8'h00, 1'b0);        // stop abandons the wait

    // long receiver hold-off while commands keep coming in
    hold_req++;
    run_setting(1, 35, 4);
    run_setting(0, 25, 3);                     // first high sample times out

    // widest limit, walked all the way to the timeout once
    write_limit(255);
    send_command(i2cmwp_pkg::OP_START, 8'($urandom), 1'($urandom));
    send_command(i2cmwp_pkg::OP_SEND_BYTE, 8'($urandom), 1'($urandom));
    ack_cycle(256, timed_out);
    run_setting(255, 15, 12);

    run_setting($urandom_range(2, 10), 45, 12);
    run_setting($urandom_range(1, 255), 25, 12);
    run_setting(int'(i2cmwp_pkg::ACK_LIMIT_RESET), 15, 6);

    wait_drained();
    if (mismatches == 0 && phases_due == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/core/i2cmwp_pkg.sv
rtl/core/i2cmwp_front.sv
rtl/core/i2cmwp_queue.sv
rtl/core/i2cmwp_back.sv
rtl/core/i2c_master_write_phaser.sv
bench/i2c_master_write_phaser_check.sv
bench/i2c_master_write_phaser_test.sv
